[hw/rtl/bnrm_pkg.sv]
// ============================================================================
// Binned running mean package
// Shared types and constants for the binned running mean block.
// ============================================================================
package bnrm_pkg;

    // Default number of bins in the table.
    localparam int BINS_DEF = 1024;

    // Saturation value of a bin's sample count.
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // The divider produces one quotient bit per cycle over a 33-bit dividend.
    localparam int DIV_STEPS = 33;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // One input word.
    typedef struct packed {
        logic        [15:0] bin_index;
        logic signed [31:0] x_sample;
        logic signed [31:0] y_sample;
    } t_in;

    // One result word.
    typedef struct packed {
        logic               index_error;
        logic signed [31:0] mean_value;
        logic        [31:0] sample_count;
        logic signed [31:0] stored_x;
    } t_out;

    // Request to the divider: magnitude of the difference over the count.
    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    // Divider status and result.
    typedef struct packed {
        logic        done;
        logic [32:0] quotient;
    } t_div_res;

endpackage

[hw/rtl/binned_running_mean.sv]
// ============================================================================
// Binned running mean
// Per-bin sample count and incremental running mean in signed Q16.16.
// ============================================================================
// Usage:
// A command word (bin index, x sample, y sample) is taken at a rising edge
// where i_start is high and o_busy is low. The block reads the bin's mean and
// count, increments the count (saturating at its maximum), divides the
// difference between y and the old mean by the new count with truncation
// toward zero, adds that step to the mean and writes the bin back.
// The result word appears on o_out for exactly one cycle, marked by o_valid,
// once the update has been written back; o_busy is high from the accepted
// command until then and drops with the strobe, so a command to a valid bin
// is finished before the next one is taken. The work runs in this order: the
// RAM read, the divider setup, the quotient bits of the radix-2 divider, the
// hand-back of the done flag and the write-back.
// A bin index at or above BINS changes nothing: the result comes in the cycle
// after the command with index_error set and all other fields zero, and the
// block can take a new command in that same cycle.
// After reset the mean/count RAM is cleared one entry per cycle, so o_busy
// stays high until the last entry is cleared.
// The receiver cannot stall; each result is valid for one cycle only.
// The x value is not stored in a bin, so the result simply
// reports the word's own x sample as the bin's stored x.
// ============================================================================
module binned_running_mean #(
    parameter int BINS = bnrm_pkg::BINS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bnrm_pkg::t_in  i_in,
    output logic           o_busy,
    output logic           o_valid,
    output bnrm_pkg::t_out o_out
);
    import bnrm_pkg::*;

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]    r_state,     n_state;
    logic [AW-1:0] r_clr_addr,  n_clr_addr;
    logic [AW-1:0] r_addr,      n_addr;
    t_in           r_item,      n_item;
    logic [31:0]   r_mean,      n_mean;
    logic [31:0]   r_cnt,       n_cnt;
    logic          r_neg,       n_neg;
    t_out          r_out,       n_out;
    logic          r_out_valid, n_out_valid;

    // The mean sits in the upper half of each RAM word, the count in the lower.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [63:0]   ram_wdata;
    logic [63:0]   ram_rdata;

    t_div_req div_req;
    t_div_res div_res;

    logic        in_range;
    logic [32:0] delta;
    logic [32:0] delta_mag;
    logic [33:0] step;
    logic [33:0] mean_sum;

    bnrm_ram #(
        .WIDTH (64),
        .DEPTH (BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    bnrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    always_comb begin
        // Compare in 17 bits so that a table of 65536 bins accepts every index.
        in_range = ({1'b0, i_in.bin_index} < 17'(BINS));

        // The difference y - mean is exact in 33 bits; its magnitude is at most 2^32.
        delta     = {r_item.y_sample[31], r_item.y_sample} - {r_mean[31], r_mean};
        delta_mag = delta[32] ? (~delta + 33'd1) : delta;

        // Apply the sign to the quotient magnitude and add it to the old mean.
        // The new mean lies between the old mean and y, so the low 32 bits suffice.
        step     = r_neg ? (~{1'b0, div_res.quotient} + 34'd1) : {1'b0, div_res.quotient};
        mean_sum = {{2{r_mean[31]}}, r_mean} + step;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_addr      = r_addr;
        n_item      = r_item;
        n_mean      = r_mean;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out       = r_out;
        n_out_valid = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = r_addr;
        ram_wdata   = '0;
        div_req     = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr_addr;
                if (r_clr_addr == AW'(BINS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                // Read the named bin speculatively; the data is used only if accepted.
                ram_addr = i_in.bin_index[AW-1:0];
                if (i_start) begin
                    if (in_range) begin
                        n_item  = i_in;
                        n_addr  = i_in.bin_index[AW-1:0];
                        n_state = S_READ;
                    end else begin
                        n_out             = '0;
                        n_out.index_error = 1'b1;
                        n_out_valid       = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_mean  = ram_rdata[63:32];
                n_cnt   = (ram_rdata[31:0] == COUNT_MAX) ? COUNT_MAX
                                                         : ram_rdata[31:0] + 32'd1;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                div_req.start    = 1'b1;
                div_req.dividend = delta_mag;
                div_req.divisor  = r_cnt;
                n_neg            = delta[32];
                n_state          = S_DIV;
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we             = 1'b1;
                ram_addr           = r_addr;
                ram_wdata          = {mean_sum[31:0], r_cnt};
                n_out.index_error  = 1'b0;
                n_out.mean_value   = mean_sum[31:0];
                n_out.sample_count = r_cnt;
                n_out.stored_x     = r_item.x_sample;
                n_out_valid        = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_item <= n_item;
        r_mean <= n_mean;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_out  <= n_out;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // A result is only ever presented once the sequencer is back in idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // A rejected index reports zeros in every other field.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.index_error) |->
        (o_out.mean_value == '0 && o_out.sample_count == '0 && o_out.stored_x == '0))
        else $error("error result carries nonzero fields");

    // An accepted update always leaves a nonzero count.
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.index_error) |-> (o_out.sample_count != '0))
        else $error("update reported a zero count");

    // An out-of-range command yields its error result on the next cycle.
    a_err_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && !in_range) |=> (o_valid && o_out.index_error))
        else $error("missing error result");

endmodule

[hw/rtl/bnrm_ram.sv]
// ============================================================================
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ============================================================================
module bnrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bnrm_div.sv]
// ============================================================================
// Radix-2 restoring divider
// Unsigned 33-bit by 32-bit division, one quotient bit per cycle.
// ============================================================================
module bnrm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bnrm_pkg::t_div_req  i_req,
    output bnrm_pkg::t_div_res  o_res
);
    import bnrm_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_step;
    logic [31:0]       r_rem;
    logic [32:0]       r_quo;
    logic [31:0]       r_div;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[32]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= DIV_CW'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[31:0] : trial[31:0];
            r_quo <= {r_quo[31:0], fits};
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_quo;

endmodule

[tb/tb_binned_running_mean.sv]
`timescale 1ns / 1ps
// ============================================================================
// Binned running mean testbench
// Drives command words into the block and checks every result word against
// a predictor that keeps its own copy of each bin's mean and count.
// ============================================================================
module tb_binned_running_mean;

    import bnrm_pkg::*;

    localparam int NUM_BINS       = BINS_DEF;
    localparam int RANDOM_WORDS   = 900;
    localparam int HOT_BINS       = 8;
    // Cycles with no word accepted on either side before the run is called
    // hung. The clearing pass after reset alone counts towards it, and a command
    // waits at most for the busy period plus the longest driver gap.
    localparam int WATCHDOG_LIMIT = 4 * NUM_BINS + 400;
    // Quiet cycles after the last expected result.
    localparam int DRAIN_CYCLES   = 60;
    localparam int REPORT_LIMIT   = 10;

    // A command word together with the idle gap the driver leaves after it
    // has been taken.
    typedef struct {
        t_in         word;
        int unsigned gap;
    } t_queued_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_in    = '0;
    logic o_busy;
    logic o_valid;
    t_out o_out;

    binned_running_mean #(
        .BINS(NUM_BINS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_in   (i_in),
        .o_busy (o_busy),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: each bin's running mean and sample count.
    logic signed [31:0] mean_tbl  [NUM_BINS];
    logic        [31:0] count_tbl [NUM_BINS];

    t_queued_word cmd_q[$];          // words waiting to be driven
    t_out         due_results_q[$];  // result words predicted, not yet seen

    int unsigned gap_left     = 0;
    int unsigned calm_left    = 0;
    int unsigned idle_cycles  = 0;
    int unsigned mismatch_cnt = 0;

    // Folds one accepted command word into the predicted bin table and
    // returns the result word the block should produce for it.
    function automatic t_out fold_sample(t_in w);
        t_out        r;
        int unsigned idx;
        logic [31:0] n;
        longint      delta;
        longint      mean_step;
        r = '0;
        if (w.bin_index >= NUM_BINS) begin
            // Out of range: nothing changes and only the error flag is set.
            r.index_error = 1'b1;
            return r;
        end
        idx = w.bin_index;
        n   = count_tbl[idx];
        if (n != COUNT_MAX) begin
            n = n + 32'd1;
        end
        count_tbl[idx] = n;
        // The difference needs 33 bits; 64-bit division truncates toward zero.
        delta          = longint'($signed(w.y_sample)) - longint'(mean_tbl[idx]);
        mean_step      = delta / longint'({32'd0, n});
        mean_tbl[idx]  = 32'(longint'(mean_tbl[idx]) + mean_step);
        r.mean_value   = mean_tbl[idx];
        r.sample_count = n;
        r.stored_x     = w.x_sample;
        return r;
    endfunction

    // Q16.16 value with weight on the extremes and on values near zero, so
    // that both tiny and full-scale differences reach the divider.
    function automatic logic signed [31:0] pick_q16();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9, 0))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            4, 5: return {{16{r[15]}}, r[15:0]};
            default: return r;
        endcase
    endfunction

    // Queues one command word. Most gaps are short, a few are long enough to
    // outlast the whole busy period, and now and then a stretch of words goes
    // out back to back with no idling at all.
    task automatic queue_word(input logic [15:0] idx, input logic signed [31:0] xs,
                              input logic signed [31:0] ys);
        t_queued_word q;
        int unsigned  roll;
        q.word.bin_index = idx;
        q.word.x_sample  = xs;
        q.word.y_sample  = ys;
        if (calm_left > 0) begin
            q.gap     = 0;
            calm_left = calm_left - 1;
        end else begin
            roll = $urandom_range(9, 0);
            if (roll < 6) begin
                q.gap = 0;
            end else if (roll < 9) begin
                q.gap = $urandom_range(4, 1);
            end else begin
                q.gap = $urandom_range(45, 10);
            end
            if ($urandom_range(39, 0) == 0) begin
                calm_left = $urandom_range(50, 15);
            end
        end
        cmd_q.push_back(q);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= REPORT_LIMIT) begin
                $display("Result field %s: expected %h, got %h", field, want, got);
            end
        end
    endtask

    // Driver. A word is taken at a rising edge with i_start high and o_busy
    // low; the prediction is made right there, from the word on i_in. While
    // i_start is low the payload carries random noise that must be ignored.
    always @(posedge i_clk) begin
        logic         launch;
        t_queued_word nxt;
        logic [95:0]  junk;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap_left = 0;
        end else begin
            junk   = {$urandom, $urandom, $urandom};
            launch = i_start;
            if (i_start && !o_busy) begin
                due_results_q.push_back(fold_sample(i_in));
                launch = 1'b0;
            end
            // The word on i_in stays put while it waits for the block.
            if (!launch) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_in <= junk[$bits(t_in)-1:0];
                end else if (cmd_q.size() != 0) begin
                    nxt = cmd_q.pop_front();
                    i_in <= nxt.word;
                    gap_left = nxt.gap;
                    launch   = 1'b1;
                end else begin
                    i_in <= junk[$bits(t_in)-1:0];
                end
            end
            i_start <= launch;
        end
    end

    // Monitor. Each result word is valid for one cycle only, so it is taken
    // whenever o_valid is high and matched with the oldest prediction. The
    // same block counts cycles in which no word moves for the watchdog.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if (o_valid) begin
                if (due_results_q.size() == 0) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= REPORT_LIMIT) begin
                        $display("Result word %h arrived with nothing expected", o_out);
                    end
                end else begin
                    want = due_results_q.pop_front();
                    check_field("index_error", {31'd0, want.index_error},
                                {31'd0, o_out.index_error});
                    check_field("mean_value", want.mean_value, o_out.mean_value);
                    check_field("sample_count", want.sample_count, o_out.sample_count);
                    check_field("stored_x", want.stored_x, o_out.stored_x);
                end
            end
            if (o_valid || (i_start && !o_busy)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [15:0] hot_bins [HOT_BINS];
        logic [15:0] idx;
        int unsigned roll;
        bit          timed_out;

        for (int b = 0; b < NUM_BINS; b++) begin
            mean_tbl[b]  = '0;
            count_tbl[b] = '0;
        end

        // Directed words. The first sample of a bin must give y exactly; the
        // second one on bin 0 and on the top bin makes the difference span
        // the full 33 bits in both directions.
        queue_word(16'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        queue_word(16'd0, 32'sh8000_0000, 32'sh8000_0000);
        queue_word(16'd0, 32'sh0000_0000, 32'sh7FFF_FFFF);
        queue_word(16'(NUM_BINS - 1), -32'sd1, 32'sh8000_0000);
        queue_word(16'(NUM_BINS - 1), 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        // Index just past the table and the largest index: both rejected.
        queue_word(16'(NUM_BINS), 32'sh1234_5678, -32'sd5);
        queue_word(16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        // Small steps on bin 1 where truncation toward zero differs from
        // flooring: mean -1, then y -2 at count 2 and y -2 at count 3.
        queue_word(16'd1, 32'sh0000_0001, -32'sd1);
        queue_word(16'd1, 32'sh0000_0002, -32'sd2);
        queue_word(16'd1, 32'sh0000_0003, -32'sd2);
        queue_word(16'd1, 32'sh0000_0004, 32'sd7);
        // A rejected word straight before and after a valid one.
        queue_word(16'h8000, 32'sh0000_0000, 32'sh0000_0000);
        queue_word(16'd2, 32'sh5555_5555, 32'shAAAA_AAAA);
        queue_word(16'h7C00, 32'shAAAA_AAAA, 32'sh5555_5555);
        queue_word(16'h0155, 32'sh5555_5555, 32'shAAAA_AAAA);
        queue_word(16'h02AA, 32'shAAAA_AAAA, 32'sh5555_5555);
        queue_word(16'h0155, 32'sh0000_0000, 32'sh0000_0000);
        queue_word(16'd2, 32'sh8000_0000, 32'sh0001_0000);

        // Random words. Close to half go to a few hot bins so that their
        // counts climb and the divider sees larger divisors; about one in ten
        // carries an index past the table, anywhere up to the largest index.
        for (int h = 0; h < HOT_BINS; h++) begin
            hot_bins[h] = 16'($urandom_range(NUM_BINS - 1, 0));
        end
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            roll = $urandom_range(99, 0);
            if (roll < 45) begin
                idx = hot_bins[$urandom_range(HOT_BINS - 1, 0)];
            end else if (roll < 90) begin
                idx = 16'($urandom_range(NUM_BINS - 1, 0));
            end else begin
                idx = 16'($urandom_range(16'hFFFF, NUM_BINS));
            end
            queue_word(idx, pick_q16(), pick_q16());
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge so the driver's and monitor's updates
        // from the rising edge are settled.
        timed_out = 1'b0;
        while (cmd_q.size() != 0 || i_start || due_results_q.size() != 0) begin
            @(negedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
        end
        if (!timed_out) begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
        if (timed_out || mismatch_cnt != 0 || due_results_q.size() != 0) begin
            $display("binned_running_mean: mismatch");
        end else begin
            $display("binned_running_mean: match");
        end
        $finish;
    end

endmodule
